### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Command codes on the command port
  localparam logic [2:0] CMD_PUT     = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_RECOLOR = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_SCROLL  = 3'd5;

  // Character and attribute constants
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT_CHAR,
    OP_NEWLINE,
    OP_WRITE,
    OP_RECOLOR,
    OP_CLEAR,
    OP_READ,
    OP_SCROLL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [7:0] attr_color;
    logic [6:0] x_pos;
    logic [4:0] y_pos;
  } item_t;

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/tcw_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
`default_nettype none

module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       hold_off,
  input  wire logic [2:0] command,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] attr_color,
  input  wire logic [6:0] x_pos,
  input  wire logic [4:0] y_pos,
  output logic            busy,
  output item_t           head,
  output logic            head_valid,
  input  wire logic       pop
);

  item_t              q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  item_t              cls;
  logic               in_range;
  logic               push;

  // Classify the incoming command
  always_comb begin
    in_range      = (32'(x_pos) < COLUMNS) && (32'(y_pos) < ROWS);
    cls.char_code  = char_code;
    cls.attr_color = attr_color;
    cls.x_pos      = x_pos;
    cls.y_pos      = y_pos;
    case (command)
      CMD_PUT:     cls.op = (char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT_CHAR;
      CMD_WRITE:   cls.op = in_range ? OP_WRITE : OP_NOP;
      CMD_RECOLOR: cls.op = OP_RECOLOR;
      CMD_CLEAR:   cls.op = OP_CLEAR;
      CMD_READ:    cls.op = in_range ? OP_READ : OP_NOP;
      CMD_SCROLL:  cls.op = OP_SCROLL;
      default:     cls.op = OP_NOP;
    endcase
  end

  assign busy       = (count == QCNT_W'(QDEPTH)) || hold_off;
  assign push       = start && !busy;
  assign head       = q[rd_ptr];
  assign head_valid = (count != '0);

  // Store queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcw_back.sv
// Back end: runs queued commands against the cell memory and the cursor.
`default_nettype none

module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  text_color,
  input  wire item_t       head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             init_busy,
  output logic             done,
  output logic [15:0]      read_entry,
  output logic [4:0]       cursor_row,
  output logic [6:0]       cursor_col
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int MOVE_CNT = (ROWS - 1) * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int KW       = $clog2(CELLS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_MOVE,
    S_RECOLOR,
    S_FILL
  } state_t;

  state_t         state;
  logic [KW-1:0]  k;
  logic [7:0]     fill_attr;
  logic [7:0]     recolor_attr;
  logic           emit;
  logic [4:0]     row;
  logic [6:0]     col;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [15:0]    wdata;
  logic [AW-1:0]  raddr;
  logic [15:0]    rdata;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  xy_addr;
  logic [AW-1:0]  k_prev;
  logic           at_last_row;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur_addr    = AW'(32'(row) * COLUMNS + 32'(col));
  assign xy_addr     = AW'(32'(head.y_pos) * COLUMNS + 32'(head.x_pos));
  assign k_prev      = AW'(k - KW'(1));
  assign at_last_row = (row == 5'(ROWS - 1));
  assign pop         = (state == S_IDLE) && head_valid;
  assign init_busy   = (state == S_FILL) && !emit;
  assign cursor_row  = row;
  assign cursor_col  = col;

  // Drive memory ports for the current step
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {text_color, head.char_code};
    raddr = xy_addr;
    case (state)
      S_IDLE: begin
        if (head_valid && head.op == OP_PUT_CHAR) begin
          we = 1'b1;
        end else if (head_valid && head.op == OP_WRITE) begin
          we    = 1'b1;
          waddr = xy_addr;
          wdata = {head.attr_color, head.char_code};
        end
      end
      S_MOVE: begin
        raddr = AW'(k + KW'(COLUMNS));
        we    = (k != '0);
        waddr = k_prev;
        wdata = rdata;
      end
      S_RECOLOR: begin
        raddr = k[AW-1:0];
        we    = (k != '0);
        waddr = k_prev;
        wdata = {recolor_attr, rdata[7:0]};
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = k[AW-1:0];
        wdata = {fill_attr, BLANK_CHAR};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Sequence commands, sweeps and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      k         <= '0;
      fill_attr <= RESET_COLOR;
      emit      <= 1'b0;
      row       <= '0;
      col       <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            case (head.op)
              OP_PUT_CHAR, OP_NEWLINE: begin
                if (head.op == OP_PUT_CHAR && col != 7'(COLUMNS - 1)) begin
                  col        <= col + 7'd1;
                  done       <= 1'b1;
                  read_entry <= '0;
                end else if (at_last_row) begin
                  col       <= '0;
                  state     <= S_MOVE;
                  k         <= '0;
                  fill_attr <= text_color;
                  emit      <= 1'b1;
                end else begin
                  col        <= '0;
                  row        <= row + 5'd1;
                  done       <= 1'b1;
                  read_entry <= '0;
                end
              end
              OP_RECOLOR: begin
                state        <= S_RECOLOR;
                k            <= '0;
                recolor_attr <= head.attr_color;
              end
              OP_CLEAR: begin
                state     <= S_FILL;
                k         <= '0;
                fill_attr <= text_color;
                emit      <= 1'b1;
                row       <= '0;
                col       <= '0;
              end
              OP_READ: begin
                state <= S_RDWAIT;
              end
              OP_SCROLL: begin
                state     <= S_MOVE;
                k         <= '0;
                fill_attr <= text_color;
                emit      <= 1'b1;
              end
              default: begin
                done       <= 1'b1;
                read_entry <= '0;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          done       <= 1'b1;
          read_entry <= rdata;
          state      <= S_IDLE;
        end
        S_MOVE: begin
          // Last move step hands over to blanking the bottom row
          if (k == KW'(MOVE_CNT)) begin
            state <= S_FILL;
          end else begin
            k <= k + KW'(1);
          end
        end
        S_RECOLOR: begin
          if (k == KW'(CELLS)) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            read_entry <= '0;
          end else begin
            k <= k + KW'(1);
          end
        end
        S_FILL: begin
          if (k == KW'(CELLS - 1)) begin
            state      <= S_IDLE;
            done       <= emit;
            read_entry <= '0;
          end else begin
            k <= k + KW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A read leaves the queue, waits in S_RDWAIT for the registered data, then gives its result
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (pop && head.op == OP_READ) |=> ##1 done)
    else $error("read result missing");

  // Cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(row) < ROWS) && (32'(col) < COLUMNS))
    else $error("cursor off screen");

  // Power-up clearing sweep gives no result
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    init_busy |=> !done)
    else $error("result during power-up clear");

endmodule

`default_nettype wire

### rtl/core/text_console_writer_unit.sv
// Top level of the text console writer: configuration register, front and back ends.
`default_nettype none

// Character-cell text screen of ROWS x COLUMNS 16-bit cells (attribute in the
// high byte, character in the low byte) with a cursor. A command is taken when
// start is high and busy is low; every command gives exactly one result beat,
// marked by done for one cycle, which the receiver cannot stall. Commands wait
// in a two-entry queue in front of the cell memory, whose single write port
// sets the cost of each command: put char, write cell and unused commands
// are finished in the idle state, read cell after a wait state for the
// registered read data. Recolor sweeps every cell, clear blanks every
// cell, and a scroll (or a put char that runs off the bottom row) moves every
// row up by one and blanks the bottom row. After reset, busy stays high for a
// clearing pass over all cells (2000 at 80x25); text_color may be written meanwhile.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         command,
  input  wire logic [7:0]         char_code,
  input  wire logic [7:0]         attr_color,
  input  wire logic [6:0]         x_pos,
  input  wire logic [4:0]         y_pos,
  output logic                    done,
  output logic [15:0]             read_entry,
  output logic [4:0]              cursor_row,
  output logic [6:0]              cursor_col,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [7:0] text_color;
  item_t      head;
  logic       head_valid;
  logic       pop;
  logic       init_busy;

  assign pready = 1'b1;

  // Hold the text color register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      text_color <= pwdata[7:0];
    end
  end

  assign prdata = paddr[2] ? '0 : PDATA_W'(text_color);

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .hold_off   (init_busy),
    .command    (command),
    .char_code  (char_code),
    .attr_color (attr_color),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .init_busy  (init_busy),
    .done       (done),
    .read_entry (read_entry),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
  );

endmodule

`default_nettype wire

### bench/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer: directed table, then random command traffic.
`timescale 1ns / 100ps

module text_console_writer_unit_tb
  import tcw_pkg::*;
();

  localparam int COLS  = COLUMNS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [PADDR_W-1:0] REG_TEXT_COLOR = 'd0;

  localparam int PHASES         = 6;
  localparam int PHASE_COMMANDS = 325;
  localparam int SETTLE_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  // One result beat: cell read back and cursor after the command
  typedef struct packed {
    logic [15:0] entry;
    logic [4:0]  row;
    logic [6:0]  col;
  } beat_t;

  // One row of the directed table
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [6:0] x;
    logic [4:0] y;
    logic       typed;
    beat_t      want;
  } probe_t;

  localparam int NPROBE = 26;
  localparam probe_t PROBES [0:NPROBE-1] = '{
    // blank screen after reset, corners and cells off the screen
    '{CMD_READ,    8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0720, 5'd0, 7'd0}},
    '{CMD_READ,    8'h00, 8'h00, 7'd79,  5'd24, 1'b1, '{16'h0720, 5'd0, 7'd0}},
    '{CMD_READ,    8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd0}},
    '{CMD_READ,    8'h00, 8'h00, 7'd80,  5'd0,  1'b1, '{16'h0000, 5'd0, 7'd0}},
    '{CMD_READ,    8'h00, 8'h00, 7'd0,   5'd25, 1'b1, '{16'h0000, 5'd0, 7'd0}},
    '{CMD_WRITE,   8'hFF, 8'hFF, 7'd79,  5'd24, 1'b1, '{16'h0000, 5'd0, 7'd0}},
    '{CMD_READ,    8'h00, 8'h00, 7'd79,  5'd24, 1'b1, '{16'hFFFF, 5'd0, 7'd0}},
    // off-screen column must not alias into the next row
    '{CMD_WRITE,   8'h41, 8'h12, 7'd127, 5'd0,  1'b1, '{16'h0000, 5'd0, 7'd0}},
    '{CMD_READ,    8'h00, 8'h00, 7'd47,  5'd1,  1'b1, '{16'h0720, 5'd0, 7'd0}},
    // put char, newline, zero character
    '{CMD_PUT,     8'h41, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd1}},
    '{CMD_PUT,     8'h0A, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd1, 7'd0}},
    '{CMD_PUT,     8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd1, 7'd1}},
    '{CMD_READ,    8'h00, 8'h00, 7'd0,   5'd1,  1'b1, '{16'h0700, 5'd1, 7'd1}},
    // unused commands change nothing
    '{CMD_SPARE6,  8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd1, 7'd1}},
    '{CMD_SPARE7,  8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd1, 7'd1}},
    // recolor keeps characters, scroll moves rows and blanks the last
    '{CMD_RECOLOR, 8'hFF, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd1, 7'd1}},
    '{CMD_READ,    8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0041, 5'd1, 7'd1}},
    '{CMD_SCROLL,  8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd1, 7'd1}},
    '{CMD_READ,    8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd1, 7'd1}},
    '{CMD_READ,    8'h00, 8'h00, 7'd79,  5'd23, 1'b1, '{16'h00FF, 5'd1, 7'd1}},
    '{CMD_READ,    8'h00, 8'h00, 7'd79,  5'd24, 1'b1, '{16'h0720, 5'd1, 7'd1}},
    '{CMD_RECOLOR, 8'h00, 8'hFF, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd1, 7'd1}},
    '{CMD_READ,    8'h00, 8'h00, 7'd5,   5'd10, 1'b1, '{16'hFF20, 5'd1, 7'd1}},
    // clear homes the cursor
    '{CMD_CLEAR,   8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd0}},
    '{CMD_PUT,     8'hFF, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd0, 7'd1}},
    '{CMD_READ,    8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h07FF, 5'd0, 7'd1}}
  };

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [2:0]        command;
  logic [7:0]        char_code;
  logic [7:0]        attr_color;
  logic [6:0]        x_pos;
  logic [4:0]        y_pos;
  logic              done;
  logic [15:0]       read_entry;
  logic [4:0]        cursor_row;
  logic [6:0]        cursor_col;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic              pready;

  // Typed expectation travels with the command it belongs to
  logic              probe_typed;
  beat_t             probe_want;

  // Screen shadow: cells, cursor and text color
  logic [15:0] shadow_cells [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  shadow_color;

  beat_t       pending_beats [$];
  int          fail_count;
  int unsigned cycles = 0;

  text_console_writer_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .char_code  (char_code),
    .attr_color (attr_color),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .done       (done),
    .read_entry (read_entry),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Fill the whole shadow screen with blanks of one attribute
  function automatic void shadow_fill(input logic [7:0] attr);
    int i;
    for (i = 0; i < CELLS; i++) shadow_cells[i] = {attr, BLANK_CHAR};
  endfunction

  // Move every row up by one and blank the bottom row
  function automatic void shadow_scroll();
    int i;
    for (i = 0; i < (ROWS - 1) * COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
    for (i = (ROWS - 1) * COLS; i < CELLS; i++) shadow_cells[i] = {shadow_color, BLANK_CHAR};
  endfunction

  // Go to column 0 of the next row, scrolling off the bottom
  function automatic void shadow_newline();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      shadow_scroll();
      cur_row = ROWS - 1;
    end else begin
      cur_row++;
    end
  endfunction

  // Apply one command to the shadow screen and return the beat it gives
  function automatic beat_t console_step(input logic [2:0] c, input logic [7:0] ch,
                                         input logic [7:0] attr, input logic [6:0] x,
                                         input logic [4:0] y);
    beat_t b;
    int    i;
    bit    on_screen;
    b.entry   = '0;
    on_screen = (int'(x) < COLS) && (int'(y) < ROWS);
    case (c)
      CMD_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          shadow_newline();
        end else begin
          if (cur_row >= ROWS || cur_col >= COLS) begin
            cur_row = 0;
            cur_col = 0;
          end
          shadow_cells[cur_row * COLS + cur_col] = {shadow_color, ch};
          cur_col++;
          if (cur_col >= COLS) shadow_newline();
        end
      end
      CMD_WRITE: begin
        if (on_screen) shadow_cells[int'(y) * COLS + int'(x)] = {attr, ch};
      end
      CMD_RECOLOR: begin
        for (i = 0; i < CELLS; i++) shadow_cells[i][15:8] = attr;
      end
      CMD_CLEAR: begin
        shadow_fill(shadow_color);
        cur_row = 0;
        cur_col = 0;
      end
      CMD_READ: begin
        if (on_screen) b.entry = shadow_cells[int'(y) * COLS + int'(x)];
      end
      CMD_SCROLL: begin
        shadow_scroll();
      end
      default: begin
      end
    endcase
    b.row = cur_row[4:0];
    b.col = cur_col[6:0];
    return b;
  endfunction

  // Check each result beat, then record the command taken at this edge
  always @(posedge clk) begin : monitor
    beat_t want;
    beat_t pred;
    if (!rst && done) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (read_entry !== want.entry) begin
          $error("read_entry: expected %h, got %h", want.entry, read_entry);
          fail_count++;
        end
        if (cursor_row !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
          fail_count++;
        end
        if (cursor_col !== want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, cursor_col);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      pred = console_step(command, char_code, attr_color, x_pos, y_pos);
      pending_beats.push_back(probe_typed ? probe_want : pred);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Gap before the next command: mostly none, some short, a few long
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one command, hold it until taken, then idle for the picked gap, if any
  task automatic issue(input logic [2:0] c, input logic [7:0] ch, input logic [7:0] attr,
                       input logic [6:0] x, input logic [4:0] y, input logic typed,
                       input beat_t want, input bit steady);
    int gap;
    command     <= c;
    char_code   <= ch;
    attr_color  <= attr;
    x_pos       <= x;
    y_pos       <= y;
    probe_typed <= typed;
    probe_want  <= want;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    gap = pick_gap(steady);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every beat is in and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0 || busy);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_TEXT_COLOR) shadow_color = data[7:0];
  endtask

  // Random cell position: mostly on screen, sometimes anywhere in the field range
  task automatic pick_cell(output logic [6:0] x, output logic [4:0] y, input bit near_cursor);
    if ($urandom_range(0, 99) < 85) begin
      x = 7'($urandom_range(0, COLS - 1));
      y = near_cursor ? 5'(cur_row) : 5'($urandom_range(0, ROWS - 1));
    end else begin
      x = 7'($urandom_range(0, 127));
      y = 5'($urandom_range(0, 31));
    end
  endtask

  initial begin : stimulus
    int         p;
    int         phase;
    int         sent;
    int         run;
    int         nl_pct;
    int         r;
    bit         steady;
    logic [2:0] c;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [6:0] x;
    logic [4:0] y;
    logic [7:0] color;
    beat_t      none;

    none         = '0;
    fail_count   = 0;
    shadow_color = RESET_COLOR;
    cur_row      = 0;
    cur_col      = 0;
    shadow_fill(RESET_COLOR);

    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_PUT;
    char_code   = '0;
    attr_color  = '0;
    x_pos       = '0;
    y_pos       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = REG_TEXT_COLOR;
    pwdata      = '0;
    probe_typed = 1'b0;
    probe_want  = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (p = 0; p < NPROBE; p++) begin
      issue(PROBES[p].cmd, PROBES[p].ch, PROBES[p].attr, PROBES[p].x, PROBES[p].y,
            PROBES[p].typed, PROBES[p].want, 1'b0);
    end

    // Random phases, each under its own text color
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       color = 8'hFF;
        1:       color = 8'h00;
        2:       color = 8'h1E;
        default: color = 8'($urandom_range(0, 255));
      endcase
      cfg_write(REG_TEXT_COLOR, PDATA_W'(color));
      sent = 0;
      while (sent < PHASE_COMMANDS) begin
        steady = ($urandom_range(0, 3) == 0);
        r      = $urandom_range(0, 99);
        if (r < 12) begin
          // Run of text: short lines, long lines that wrap, or many newlines
          run = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 12);
          case ($urandom_range(0, 2))
            0:       nl_pct = 0;
            1:       nl_pct = 4;
            default: nl_pct = 35;
          endcase
          repeat (run) begin
            ch = ($urandom_range(0, 99) < nl_pct) ? NEWLINE_CHAR : 8'($urandom_range(0, 255));
            issue(CMD_PUT, ch, 8'($urandom), 7'($urandom), 5'($urandom), 1'b0, none, steady);
            sent++;
          end
        end else begin
          // Single command with random fields
          r    = $urandom_range(0, 99);
          ch   = 8'($urandom_range(0, 255));
          attr = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                             : 8'($urandom_range(0, 255));
          pick_cell(x, y, $urandom_range(0, 1) == 1);
          if (r < 35)      c = CMD_WRITE;
          else if (r < 70) c = CMD_READ;
          else if (r < 76) c = CMD_RECOLOR;
          else if (r < 80) c = CMD_CLEAR;
          else if (r < 88) c = CMD_SCROLL;
          else if (r < 91) c = CMD_SPARE6;
          else if (r < 94) c = CMD_SPARE7;
          else             c = CMD_PUT;
          issue(c, ch, attr, x, y, 1'b0, none, steady);
          sent++;
        end
      end
    end

    // Drain and settle
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $error("%0d result beats never arrived", pending_beats.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
